FILE: rtl/dmcs_pkg.sv
// ----------------------------------------------------------------------------
// dmcs_pkg
// Shared widths, defaults and codes for the direct-mapped cache model.
// ----------------------------------------------------------------------------
package dmcs_pkg;

  localparam int DEF_WORDS_PER_BLOCK = 4;
  localparam int DEF_LINES           = 8;
  localparam int DEF_MEM_BLOCKS      = 32;

  localparam int OP_W        = 1;
  localparam int ADDR_W      = 7;
  localparam int ADDR_SPAN   = 1 << ADDR_W;
  localparam int DATA_W      = 32;
  localparam int LINE_OUT_W  = 3;
  localparam int BLOCK_OUT_W = 5;
  localparam int CNT_W       = 32;

  localparam logic [OP_W-1:0] OP_READ  = 1'b0;
  localparam logic [OP_W-1:0] OP_WRITE = 1'b1;

  function automatic int clog2_min1(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

  function automatic int back_depth(input int wpb, input int mem_blocks);
    return ((wpb * mem_blocks) < ADDR_SPAN) ? (wpb * mem_blocks) : ADDR_SPAN;
  endfunction

endpackage

FILE: rtl/dmcs_ram.sv
// ----------------------------------------------------------------------------
// dmcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dmcs_addr_dec.sv
// ----------------------------------------------------------------------------
// dmcs_addr_dec
// Address decode: wrapped word address, block, offset, line and RAM indexes,
// from a constant table over the whole address space.
// ----------------------------------------------------------------------------
module dmcs_addr_dec #(
  parameter int WORDS_PER_BLOCK = dmcs_pkg::DEF_WORDS_PER_BLOCK,
  parameter int LINES           = dmcs_pkg::DEF_LINES,
  parameter int MEM_BLOCKS      = dmcs_pkg::DEF_MEM_BLOCKS,
  localparam int MemWords  = WORDS_PER_BLOCK * MEM_BLOCKS,
  localparam int BackDepth = dmcs_pkg::back_depth(WORDS_PER_BLOCK, MEM_BLOCKS),
  localparam int BackAw    = dmcs_pkg::clog2_min1(BackDepth),
  localparam int BlkCount  = (BackDepth + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK,
  localparam int BlkW      = dmcs_pkg::clog2_min1(BlkCount),
  localparam int LineW     = dmcs_pkg::clog2_min1(LINES),
  localparam int OffW      = dmcs_pkg::clog2_min1(WORDS_PER_BLOCK),
  localparam int CacheAw   = dmcs_pkg::clog2_min1(LINES * WORDS_PER_BLOCK)
) (
  input  logic [dmcs_pkg::ADDR_W-1:0] address,
  output logic [BackAw-1:0]           waddr,
  output logic [BackAw-1:0]           bbase,
  output logic [BlkW-1:0]             blk,
  output logic [OffW-1:0]             off,
  output logic [LineW-1:0]            line,
  output logic [CacheAw-1:0]          cidx,
  output logic [CacheAw-1:0]          cbase
);

  import dmcs_pkg::*;

  logic [BackAw-1:0]  waddr_tab [ADDR_SPAN];
  logic [BackAw-1:0]  bbase_tab [ADDR_SPAN];
  logic [BlkW-1:0]    blk_tab   [ADDR_SPAN];
  logic [OffW-1:0]    off_tab   [ADDR_SPAN];
  logic [LineW-1:0]   line_tab  [ADDR_SPAN];
  logic [CacheAw-1:0] cidx_tab  [ADDR_SPAN];
  logic [CacheAw-1:0] cbase_tab [ADDR_SPAN];

  for (genvar a = 0; a < ADDR_SPAN; a++) begin : g_tab
    localparam int Wa  = a % MemWords;
    localparam int Blk = Wa / WORDS_PER_BLOCK;
    localparam int Off = Wa % WORDS_PER_BLOCK;
    localparam int Ln  = Blk % LINES;
    assign waddr_tab[a] = BackAw'(Wa);
    assign bbase_tab[a] = BackAw'(Wa - Off);
    assign blk_tab[a]   = BlkW'(Blk);
    assign off_tab[a]   = OffW'(Off);
    assign line_tab[a]  = LineW'(Ln);
    assign cidx_tab[a]  = CacheAw'(Ln * WORDS_PER_BLOCK + Off);
    assign cbase_tab[a] = CacheAw'(Ln * WORDS_PER_BLOCK);
  end

  assign waddr = waddr_tab[address];
  assign bbase = bbase_tab[address];
  assign blk   = blk_tab[address];
  assign off   = off_tab[address];
  assign line  = line_tab[address];
  assign cidx  = cidx_tab[address];
  assign cbase = cbase_tab[address];

endmodule

FILE: rtl/direct_mapped_cache_sim_top.sv
// ----------------------------------------------------------------------------
// Flow: a request is registered in S_IDLE, looked up in S_LOOK, refilled in
// S_FILL on a miss and answered from S_DONE once the output is free; in_stall
// holds off new requests until then; refill reads one memory word per cycle.
// Reset: line valid bits, main memory valid bits and both counters clear
// at once; no clearing pass.
// ----------------------------------------------------------------------------
// direct_mapped_cache_sim_top
// Direct-mapped, write-through, write-allocate cache over a word-addressed
// main memory, with saturating hit and miss counters.
// ----------------------------------------------------------------------------
module direct_mapped_cache_sim_top #(
  parameter int WORDS_PER_BLOCK = dmcs_pkg::DEF_WORDS_PER_BLOCK,
  parameter int LINES           = dmcs_pkg::DEF_LINES,
  parameter int MEM_BLOCKS      = dmcs_pkg::DEF_MEM_BLOCKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dmcs_pkg::OP_W-1:0]        in_operation,
  input  logic [dmcs_pkg::ADDR_W-1:0]      in_address,
  input  logic [dmcs_pkg::DATA_W-1:0]      in_write_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_was_hit,
  output logic [dmcs_pkg::LINE_OUT_W-1:0]  out_line_used,
  output logic [dmcs_pkg::BLOCK_OUT_W-1:0] out_block_number,
  output logic [dmcs_pkg::DATA_W-1:0]      out_read_data,
  output logic [dmcs_pkg::CNT_W-1:0]       out_hit_total,
  output logic [dmcs_pkg::CNT_W-1:0]       out_miss_total
);

  import dmcs_pkg::*;

  localparam int BackDepth  = back_depth(WORDS_PER_BLOCK, MEM_BLOCKS);
  localparam int BackAw     = clog2_min1(BackDepth);
  localparam int BlkCount   = (BackDepth + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK;
  localparam int BlkW       = clog2_min1(BlkCount);
  localparam int LineW      = clog2_min1(LINES);
  localparam int OffW       = clog2_min1(WORDS_PER_BLOCK);
  localparam int CacheDepth = LINES * WORDS_PER_BLOCK;
  localparam int CacheAw    = clog2_min1(CacheDepth);
  localparam int EntW       = DATA_W + BlkW;
  localparam logic [OffW-1:0] LastCnt = OffW'(WORDS_PER_BLOCK - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FILL,
    S_DONE
  } state_t;

  state_t state_r;

  logic [BackAw-1:0]  dec_waddr, dec_bbase;
  logic [BlkW-1:0]    dec_blk;
  logic [OffW-1:0]    dec_off;
  logic [LineW-1:0]   dec_line;
  logic [CacheAw-1:0] dec_cidx, dec_cbase;

  logic [OP_W-1:0]    op_r;
  logic [DATA_W-1:0]  data_r;
  logic [BackAw-1:0]  bbase_r;
  logic [BlkW-1:0]    blk_r;
  logic [OffW-1:0]    off_r;
  logic [LineW-1:0]   line_r;
  logic [CacheAw-1:0] cidx_r, cbase_r;
  logic [OffW-1:0]    cnt_r;
  logic               res_hit_r;
  logic [DATA_W-1:0]  res_data_r;
  logic [CNT_W-1:0]   hit_cnt_r, miss_cnt_r;
  logic [CNT_W-1:0]   hit_cnt_nxt, miss_cnt_nxt;
  logic               lvld_r [LINES];
  logic               bvld_r [BackDepth];
  logic               bvld_rd_r;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [LINE_OUT_W-1:0]  out_line_r;
  logic [BLOCK_OUT_W-1:0] out_block_r;
  logic [DATA_W-1:0]      out_data_r;
  logic [CNT_W-1:0]       out_hits_r, out_misses_r;

  logic               c_we;
  logic [CacheAw-1:0] c_waddr;
  logic [EntW-1:0]    c_wdata, c_rdata;
  logic               b_we;
  logic [BackAw-1:0]  b_raddr;
  logic [DATA_W-1:0]  b_rdata, bword;
  logic               hit, out_free;

  dmcs_addr_dec #(
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
    .LINES           (LINES),
    .MEM_BLOCKS      (MEM_BLOCKS)
  ) u_dec (
    .address (in_address),
    .waddr   (dec_waddr),
    .bbase   (dec_bbase),
    .blk     (dec_blk),
    .off     (dec_off),
    .line    (dec_line),
    .cidx    (dec_cidx),
    .cbase   (dec_cbase)
  );

  // line words, each tagged with the block of its line
  dmcs_ram #(
    .WIDTH (EntW),
    .DEPTH (CacheDepth)
  ) u_cache_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (dec_cidx),
    .rdata (c_rdata)
  );

  dmcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BackDepth)
  ) u_back_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (dec_waddr),
    .wdata (in_write_data),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign b_we     = in_valid && (state_r == S_IDLE) && (in_operation == OP_WRITE);
  assign bword    = bvld_rd_r ? b_rdata : '0;
  assign hit      = lvld_r[line_r] && (c_rdata[EntW-1:DATA_W] == blk_r);

  assign hit_cnt_nxt  = (&hit_cnt_r) ? hit_cnt_r : hit_cnt_r + CNT_W'(1);
  assign miss_cnt_nxt = (&miss_cnt_r) ? miss_cnt_r : miss_cnt_r + CNT_W'(1);

  always_comb begin
    c_we    = 1'b0;
    c_waddr = cidx_r;
    c_wdata = {blk_r, data_r};
    b_raddr = bbase_r;
    unique case (state_r)
      S_LOOK: begin
        c_we = hit && (op_r == OP_WRITE);
      end
      S_FILL: begin
        c_we    = 1'b1;
        c_waddr = cbase_r + CacheAw'(cnt_r);
        c_wdata = {blk_r, bword};
        if (cnt_r != LastCnt) begin
          b_raddr = bbase_r + BackAw'(cnt_r) + BackAw'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bvld_rd_r <= bvld_r[b_raddr];
    if (!rst_n) begin
      for (int i = 0; i < BackDepth; i++) begin
        bvld_r[i] <= 1'b0;
      end
    end else if (b_we) begin
      bvld_r[dec_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      for (int i = 0; i < LINES; i++) begin
        lvld_r[i] <= 1'b0;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            data_r  <= in_write_data;
            bbase_r <= dec_bbase;
            blk_r   <= dec_blk;
            off_r   <= dec_off;
            line_r  <= dec_line;
            cidx_r  <= dec_cidx;
            cbase_r <= dec_cbase;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          cnt_r     <= '0;
          res_hit_r <= hit;
          if (hit) begin
            res_data_r <= (op_r == OP_WRITE) ? data_r : c_rdata[DATA_W-1:0];
            hit_cnt_r  <= hit_cnt_nxt;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          if (cnt_r == off_r) begin
            res_data_r <= bword;
          end
          if (cnt_r == LastCnt) begin
            lvld_r[line_r] <= 1'b1;
            miss_cnt_r     <= miss_cnt_nxt;
            state_r        <= S_DONE;
          end else begin
            cnt_r <= cnt_r + OffW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_hit_r    <= res_hit_r;
            out_line_r   <= LINE_OUT_W'(line_r);
            out_block_r  <= BLOCK_OUT_W'(blk_r);
            out_data_r   <= res_data_r;
            out_hits_r   <= hit_cnt_r;
            out_misses_r <= miss_cnt_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_was_hit      = out_hit_r;
  assign out_line_used    = out_line_r;
  assign out_block_number = out_block_r;
  assign out_read_data    = out_data_r;
  assign out_hit_total    = out_hits_r;
  assign out_miss_total   = out_misses_r;

endmodule
